FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the MJD-to-calendar converter.
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
`define ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## dly (cons)) \
    else $error("assertion failed: delayed implication");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons)
`endif
`endif

FILE: rtl/mjdcal_pkg.sv
// Shared constants, types and tables for the MJD-to-calendar converter.
// No dependencies.
`default_nettype none

package mjdcal_pkg;

    // field widths
    localparam int MjdW   = 18;
    localparam int FracW  = 32;
    localparam int YearW  = 12;
    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int HourW  = 5;
    localparam int MinW   = 6;
    localparam int SecW   = 22;

    // pipeline shape
    localparam int PipeDepth = 7;
    localparam int TodStages = 3;

    // date path: n = 100*B - 12210 = 100*mjd + 240141590
    localparam int NW = 28;
    localparam logic [NW-1:0] N_SCALE  = 28'd100;
    localparam logic [NW-1:0] N_OFFSET = 28'd240141590;

    // floor(n / 36525) by reciprocal, low by at most one before correction
    localparam int CW          = 13;
    localparam int RecipShift  = 38;
    localparam int RecipW      = 23;
    localparam logic [RecipW-1:0] RECIP = RecipW'((64'd1 << RecipShift) / 64'd36525);
    localparam int PW          = 29;
    localparam logic [PW-1:0] YEAR_DIV = 29'd36525;

    // floor(365.25*C) = (1461*C) >> 2
    localparam int QW = 24;
    localparam logic [QW-1:0] QUAD_MUL = 24'd1461;
    localparam int BW = 22;
    localparam logic [BW-1:0] MJD_TO_B = 22'd2401538;

    // days into the March-based year, and month index E
    localparam int GW = 9;
    localparam int EW = 4;
    localparam int EMax = 15;
    localparam logic [EW-1:0] MONTH_WRAP = 4'd14;
    localparam logic [EW-1:0] MONTH_ADJ_LO = 4'd1;
    localparam logic [EW-1:0] MONTH_ADJ_HI = 4'd13;
    localparam logic [MonthW-1:0] MARCH = 4'd3;
    localparam logic [CW-1:0] YEAR_BASE = 13'd4715;

    // time of day multipliers
    localparam int TW = 38;
    localparam logic [TW-1:0] HOURS_PER_DAY = 38'd24;
    localparam logic [TW-1:0] SIXTY = 38'd60;

    typedef struct packed {
        logic [HourW-1:0] hour;
        logic [MinW-1:0]  minute;
        logic [SecW-1:0]  second_q16;
    } tod_t;

    // floor(30.6001 * e)
    function automatic logic [GW-1:0] month_floor(input logic [EW-1:0] e);
        logic [GW-1:0] v;
        unique case (e)
            4'd0:  v = 9'd0;
            4'd1:  v = 9'd30;
            4'd2:  v = 9'd61;
            4'd3:  v = 9'd91;
            4'd4:  v = 9'd122;
            4'd5:  v = 9'd153;
            4'd6:  v = 9'd183;
            4'd7:  v = 9'd214;
            4'd8:  v = 9'd244;
            4'd9:  v = 9'd275;
            4'd10: v = 9'd306;
            4'd11: v = 9'd336;
            4'd12: v = 9'd367;
            4'd13: v = 9'd397;
            4'd14: v = 9'd428;
            4'd15: v = 9'd459;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mjdcal_date.sv
// Seven-stage date path: MJD day count to Gregorian year, month, day.
// Depends on mjdcal_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mjdcal_date (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [mjdcal_pkg::MjdW-1:0]        mjd_days,
    output logic                               out_valid,
    output logic [mjdcal_pkg::YearW-1:0]       year,
    output logic [mjdcal_pkg::MonthW-1:0]      month,
    output logic [mjdcal_pkg::DayW-1:0]        day_of_month
);

    localparam int NW = mjdcal_pkg::NW;
    localparam int CW = mjdcal_pkg::CW;
    localparam int PW = mjdcal_pkg::PW;
    localparam int GW = mjdcal_pkg::GW;
    localparam int EW = mjdcal_pkg::EW;
    localparam int MW = mjdcal_pkg::MjdW;
    localparam int QW = mjdcal_pkg::QW;
    localparam int BW = mjdcal_pkg::BW;
    localparam int YW = mjdcal_pkg::YearW;
    localparam int ProdW = NW + mjdcal_pkg::RecipW;

    logic [mjdcal_pkg::PipeDepth-1:0] vld_reg;

    // stage 1
    logic [NW-1:0] n1_reg, n1_next;
    logic [MW-1:0] d1_reg;
    // stage 2
    logic [ProdW-1:0] prod2;
    logic [CW-1:0] q2_reg, q2_next;
    logic [NW-1:0] n2_reg;
    logic [MW-1:0] d2_reg;
    // stage 3
    logic [PW-1:0] p3_reg, p3_next;
    logic [CW-1:0] q3_reg;
    logic [NW-1:0] n3_reg;
    logic [MW-1:0] d3_reg;
    // stage 4
    logic [PW-1:0] rem4;
    logic [CW-1:0] c4_reg, c4_next;
    logic [MW-1:0] d4_reg;
    // stage 5
    logic [QW-1:0] quad5;
    logic [BW-1:0] b5, dd5, g5_full;
    logic [GW-1:0] g5_reg, g5_next;
    logic [CW-1:0] c5_reg;
    // stage 6
    logic [EW-1:0] e6_reg, e6_next;
    logic [GW-1:0] g6_reg;
    logic [CW-1:0] c6_reg;
    // stage 7
    logic [GW-1:0] day7;
    logic [mjdcal_pkg::MonthW-1:0] month_reg, month_next;
    logic [mjdcal_pkg::DayW-1:0]   day_reg, day_next;
    logic [mjdcal_pkg::YearW-1:0]  year_reg, year_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[mjdcal_pkg::PipeDepth-2:0], in_valid};
        end
    end

    always_comb
    begin
        n1_next = NW'(mjd_days) * mjdcal_pkg::N_SCALE + mjdcal_pkg::N_OFFSET;
    end

    always_comb
    begin
        prod2   = ProdW'(n1_reg) * ProdW'(mjdcal_pkg::RECIP);
        q2_next = prod2[mjdcal_pkg::RecipShift +: CW];
    end

    always_comb
    begin
        p3_next = PW'(q2_reg) * mjdcal_pkg::YEAR_DIV;
    end

    // quotient estimate is at most one low; one compare fixes it
    always_comb
    begin
        rem4    = PW'(n3_reg) - p3_reg;
        c4_next = q3_reg + CW'(rem4 >= mjdcal_pkg::YEAR_DIV);
    end

    always_comb
    begin
        quad5   = QW'(c4_reg) * mjdcal_pkg::QUAD_MUL;
        dd5     = quad5[QW-1:2];
        b5      = BW'(d4_reg) + mjdcal_pkg::MJD_TO_B;
        g5_full = b5 - dd5;
        g5_next = g5_full[GW-1:0];
    end

    // E = floor(G / 30.6001): count month boundaries strictly below G
    always_comb
    begin
        e6_next = '0;
        for (int k = 1; k <= mjdcal_pkg::EMax; k++)
        begin
            if (g5_reg > mjdcal_pkg::month_floor(EW'(k)))
            begin
                e6_next = e6_next + EW'(1);
            end
        end
    end

    always_comb
    begin
        day7     = g6_reg - mjdcal_pkg::month_floor(e6_reg);
        day_next = day7[mjdcal_pkg::DayW-1:0];
        if (e6_reg < mjdcal_pkg::MONTH_WRAP)
        begin
            month_next = e6_reg - mjdcal_pkg::MONTH_ADJ_LO;
        end
        else
        begin
            month_next = e6_reg - mjdcal_pkg::MONTH_ADJ_HI;
        end
        year_next = YW'(c6_reg - mjdcal_pkg::YEAR_BASE
                        - CW'(month_next >= mjdcal_pkg::MARCH));
    end

    always_ff @(posedge clk)
    begin
        n1_reg    <= n1_next;
        d1_reg    <= mjd_days;
        q2_reg    <= q2_next;
        n2_reg    <= n1_reg;
        d2_reg    <= d1_reg;
        p3_reg    <= p3_next;
        q3_reg    <= q2_reg;
        n3_reg    <= n2_reg;
        d3_reg    <= d2_reg;
        c4_reg    <= c4_next;
        d4_reg    <= d3_reg;
        g5_reg    <= g5_next;
        c5_reg    <= c4_reg;
        e6_reg    <= e6_next;
        g6_reg    <= g5_reg;
        c6_reg    <= c5_reg;
        month_reg <= month_next;
        day_reg   <= day_next;
        year_reg  <= year_next;
    end

    // c5 feeds stage 6 only through c6
    assign out_valid    = vld_reg[mjdcal_pkg::PipeDepth-1];
    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = day_reg;

    `ASSERT_IMPL(a_month_range, clk, rst_n, out_valid, (month >= 4'd1) && (month <= 4'd12))
    `ASSERT_IMPL(a_day_range, clk, rst_n, out_valid, (day_of_month >= 5'd1))
    `ASSERT_IMPL(a_e_range, clk, rst_n, vld_reg[5], (e6_reg >= 4'd4))

endmodule

`default_nettype wire

FILE: rtl/mjdcal_tod.sv
// Time-of-day path: Q0.32 day fraction to hour, minute, Q16 seconds,
// padded to the date path latency. Depends on mjdcal_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mjdcal_tod (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [mjdcal_pkg::FracW-1:0]    day_fraction,
    output logic                            out_valid,
    output mjdcal_pkg::tod_t                tod
);

    localparam int TW    = mjdcal_pkg::TW;
    localparam int FW    = mjdcal_pkg::FracW;
    localparam int Delay = mjdcal_pkg::PipeDepth - mjdcal_pkg::TodStages;

    logic [mjdcal_pkg::PipeDepth-1:0] vld_reg;

    logic [TW-1:0] t1, m2, s3;
    logic [mjdcal_pkg::HourW-1:0] hr1_reg, hr2_reg;
    logic [FW-1:0] r1_reg, r1_next, r2_reg, r2_next;
    logic [mjdcal_pkg::MinW-1:0] mn2_reg;
    mjdcal_pkg::tod_t res3_next;
    mjdcal_pkg::tod_t dly_reg [Delay+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[mjdcal_pkg::PipeDepth-2:0], in_valid};
        end
    end

    always_comb
    begin
        t1      = TW'(day_fraction) * mjdcal_pkg::HOURS_PER_DAY;
        r1_next = t1[FW-1:0];
        m2      = TW'(r1_reg) * mjdcal_pkg::SIXTY;
        r2_next = m2[FW-1:0];
        s3      = TW'(r2_reg) * mjdcal_pkg::SIXTY;
        res3_next.hour       = hr2_reg;
        res3_next.minute     = mn2_reg;
        res3_next.second_q16 = s3[TW-1 -: mjdcal_pkg::SecW];
    end

    always_ff @(posedge clk)
    begin
        hr1_reg    <= t1[FW +: mjdcal_pkg::HourW];
        r1_reg     <= r1_next;
        hr2_reg    <= hr1_reg;
        mn2_reg    <= m2[FW +: mjdcal_pkg::MinW];
        r2_reg     <= r2_next;
        dly_reg[0] <= res3_next;
        for (int i = 1; i <= Delay; i++)
        begin
            dly_reg[i] <= dly_reg[i-1];
        end
    end

    assign out_valid = vld_reg[mjdcal_pkg::PipeDepth-1];
    assign tod       = dly_reg[Delay];

    `ASSERT_IMPL(a_hour_range, clk, rst_n, out_valid, tod.hour <= 5'd23)
    `ASSERT_IMPL(a_minute_range, clk, rst_n, out_valid, tod.minute <= 6'd59)
    `ASSERT_IMPL(a_second_range, clk, rst_n, out_valid, tod.second_q16 <= 22'd3932159)

endmodule

`default_nettype wire

FILE: rtl/mjd_to_calendar_date.sv
// MJD day count plus Q0.32 day fraction to Gregorian date and time of day.
// Throughput is one transaction per cycle; busy stays low and the receiver
// cannot stall.
// The date path sets the depth: reciprocal multiply, back-multiply and fixup
// for 365.25, then 1461*C, a compare bank for 30.6001 and the final sums.
// Reset (rst_n, async, active low) clears only the valid bits; no state is kept.
`default_nettype none
`include "assert_macros.svh"

module mjd_to_calendar_date (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [mjdcal_pkg::MjdW-1:0]     mjd_days,
    input  logic [mjdcal_pkg::FracW-1:0]    day_fraction,
    output logic                            done,
    output logic [mjdcal_pkg::YearW-1:0]    year,
    output logic [mjdcal_pkg::MonthW-1:0]   month,
    output logic [mjdcal_pkg::DayW-1:0]     day_of_month,
    output logic [mjdcal_pkg::HourW-1:0]    hour,
    output logic [mjdcal_pkg::MinW-1:0]     minute,
    output logic [mjdcal_pkg::SecW-1:0]     second_q16
);

    // The pipeline never stalls, so a transaction is taken on every start.
    logic             accept;
    logic             date_valid;
    logic             tod_valid;
    mjdcal_pkg::tod_t tod;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Date path: B = mjd + 2401538, C, D, E, then day/month/year.
    mjdcal_date u_date (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .mjd_days     (mjd_days),
        .out_valid    (date_valid),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month)
    );

    // Time path: three exact fixed-point multiplies, delayed to line up.
    mjdcal_tod u_tod (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .day_fraction (day_fraction),
        .out_valid    (tod_valid),
        .tod          (tod)
    );

    assign done       = date_valid;
    assign hour       = tod.hour;
    assign minute     = tod.minute;
    assign second_q16 = tod.second_q16;

    // both halves of a result must leave together
    `ASSERT_ALWAYS(a_paths_aligned, clk, rst_n, date_valid == tod_valid)
    // every accepted transaction comes out as a done strobe at the pipeline end
    `ASSERT_DELAY(a_latency, clk, rst_n, accept, 7, done)
    `ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

endmodule

`default_nettype wire

FILE: tb/mjd_to_calendar_date_chk.sv
// Checker for the MJD-to-calendar converter: predicts date and time of day
// for each accepted transaction and compares every done strobe in order.
// Depends on mjdcal_pkg for field widths.
`timescale 1ns / 1ps

module mjd_to_calendar_date_chk
    import mjdcal_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [MjdW-1:0]   mjd_days,
    input  logic [FracW-1:0]  day_fraction,
    input  logic              done,
    input  logic [YearW-1:0]  year,
    input  logic [MonthW-1:0] month,
    input  logic [DayW-1:0]   day_of_month,
    input  logic [HourW-1:0]  hour,
    input  logic [MinW-1:0]   minute,
    input  logic [SecW-1:0]   second_q16,
    output int                n_errors,
    output int                n_pending,
    output int                n_accepted,
    output int                n_checked
);

    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   dom;
        logic [HourW-1:0]  hour;
        logic [MinW-1:0]   minute;
        logic [SecW-1:0]   sec;
    } cal_time_t;

    cal_time_t pending_dates[$];

    // Julian-day inversion with 365.25 and 30.6001 scaled to integers,
    // then the time of day peeled off the Q0.32 fraction in three multiplies
    function automatic cal_time_t mjd_to_cal_time(input logic [MjdW-1:0] days,
                                                  input logic [FracW-1:0] frac);
        logic [63:0] b, c, d, e, dom, mon, yr, t, m, s;
        cal_time_t res;
        b   = 64'(days) + 64'(MJD_TO_B);
        c   = (64'd100 * b - 64'd12210) / 64'd36525;
        d   = (64'd1461 * c) / 64'd4;
        e   = (64'd10000 * (b - d)) / 64'd306001;
        dom = b - d - (64'd306001 * e) / 64'd10000;
        mon = e - 64'd1 - 64'd12 * (e / 64'd14);
        yr  = c - 64'd4715 - (64'd7 + mon) / 64'd10;
        t   = 64'd24 * 64'(frac);
        m   = 64'd60 * {32'd0, t[31:0]};
        s   = 64'd60 * {32'd0, m[31:0]};
        res.year   = yr[YearW-1:0];
        res.month  = mon[MonthW-1:0];
        res.dom    = dom[DayW-1:0];
        res.hour   = t[32 +: HourW];
        res.minute = m[32 +: MinW];
        res.sec    = s[16 +: SecW];
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        cal_time_t want;
        if (!rst_n) begin
            pending_dates.delete();
            n_errors   <= 0;
            n_pending  <= 0;
            n_accepted <= 0;
            n_checked  <= 0;
        end else begin
            // compare first: a result on this edge belongs to an earlier transaction
            if (done) begin
                if (pending_dates.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %0d-%0d-%0d",
                             $time, year, month, day_of_month);
                    n_errors++;
                end else begin
                    want = pending_dates.pop_front();
                    compare_field("year", 32'(want.year), 32'(year));
                    compare_field("month", 32'(want.month), 32'(month));
                    compare_field("day_of_month", 32'(want.dom), 32'(day_of_month));
                    compare_field("hour", 32'(want.hour), 32'(hour));
                    compare_field("minute", 32'(want.minute), 32'(minute));
                    compare_field("second_q16", 32'(want.sec), 32'(second_q16));
                    n_checked++;
                end
            end
            if (start && !busy) begin
                pending_dates.push_back(mjd_to_cal_time(mjd_days, day_fraction));
                n_accepted++;
            end
            n_pending = pending_dates.size();
        end
    end

endmodule

FILE: tb/mjd_to_calendar_date_tb.sv
// Top of the MJD-to-calendar testbench: clock, reset, stimulus and verdict.
// Depends on mjdcal_pkg, the mjd_to_calendar_date RTL and mjd_to_calendar_date_chk.
`timescale 1ns / 1ps

module mjd_to_calendar_date_tb;
    import mjdcal_pkg::*;

    localparam int NumRandom  = 1850;
    // 2^32 / 1440: one minute expressed as a Q0.32 day fraction (rounded down)
    localparam logic [FracW-1:0] MINUTE_FRAC = 32'h002D82D8;
    // 2^32 / 24: one hour as a day fraction (rounded down)
    localparam logic [FracW-1:0] HOUR_FRAC   = 32'h0AAAAAAA;
    // MJD of the edges where the fixed-offset inversion stops matching Gregorian
    localparam logic [MjdW-1:0] MJD_1900_MAR01 = 18'd15079;
    localparam logic [MjdW-1:0] MJD_2100_FEB28 = 18'd88127;
    localparam logic [MjdW-1:0] MJD_2000_JAN01 = 18'd51544;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [MjdW-1:0]   mjd_days;
    logic [FracW-1:0]  day_fraction;
    logic              done;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day_of_month;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second_q16;

    int n_errors, n_pending, n_accepted, n_checked;
    bit gaps_on;

    mjd_to_calendar_date u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mjd_days     (mjd_days),
        .day_fraction (day_fraction),
        .done         (done),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second_q16   (second_q16)
    );

    // The checker sees the same pins as the block; it owns all prediction.
    mjd_to_calendar_date_chk u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mjd_days     (mjd_days),
        .day_fraction (day_fraction),
        .done         (done),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second_q16   (second_q16),
        .n_errors     (n_errors),
        .n_pending    (n_pending),
        .n_accepted   (n_accepted),
        .n_checked    (n_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: the slowest legal run takes about 10 us,
    // so 400 us only trips on a hung handshake or a lost result.
    initial
    begin
        #400us;
        $display("Timeout waiting on the converter");
        $display("Regression FAIL");
        $finish;
    end

    // Present one timestamp and hold it until the block takes it. start stays
    // high into the next call unless a random gap drops it, so back-to-back
    // transactions never see start lowered and raised within one step.
    task automatic send_timestamp(input logic [MjdW-1:0] days, input logic [FracW-1:0] frac);
        start        <= 1'b1;
        mjd_days     <= days;
        day_fraction <= frac;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge; a random gap may leave start low behind it
        while (gaps_on && $urandom_range(0, 99) < 9) begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Day numbers: half uniform over all 18 bits, the other half clustered on
    // the century-rule edges, the modern era and both ends of the range.
    function automatic logic [MjdW-1:0] pick_days();
        logic [MjdW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = MjdW'($urandom);
            5:       v = MJD_1900_MAR01 + MjdW'($urandom_range(0, 6)) - MjdW'(3);
            6:       v = MJD_2100_FEB28 + MjdW'($urandom_range(0, 6)) - MjdW'(3);
            7:       v = MjdW'($urandom_range(40000, 70000));
            8:       v = MjdW'($urandom_range(0, 400));
            default: v = MjdW'(262143 - $urandom_range(0, 400));
        endcase
        return v;
    endfunction

    // Day fractions: mostly uniform, the rest right at minute and hour
    // boundaries (where truncation bites) and at the very ends of the day.
    function automatic logic [FracW-1:0] pick_fraction();
        logic [63:0] edge_pt;
        logic [FracW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = $urandom;
            6: begin
                edge_pt = (64'($urandom_range(0, 1440)) << 32) / 64'd1440;
                v = FracW'(edge_pt) + FracW'($urandom_range(0, 4)) - FracW'(2);
            end
            7: begin
                edge_pt = (64'($urandom_range(0, 24)) << 32) / 64'd24;
                v = FracW'(edge_pt) + FracW'($urandom_range(0, 4)) - FracW'(2);
            end
            8:       v = FracW'($urandom_range(0, 255));
            default: v = 32'hFFFF_FFFF - FracW'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        mjd_days     <= '0;
        day_fraction <= '0;
        gaps_on      = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, alternating bit patterns
        send_timestamp(18'd0, 32'h0000_0000);
        send_timestamp(18'd262143, 32'hFFFF_FFFF);
        send_timestamp(18'd131072, 32'h5555_5555);
        send_timestamp(18'd131071, 32'hAAAA_AAAA);
        send_timestamp(18'h15555, 32'h8000_0000);
        send_timestamp(18'h2AAAA, 32'h0000_0001);
        // century leap rule: last true dates at both ends, and one past each
        send_timestamp(MJD_1900_MAR01 - 18'd1, 32'h8000_0000);
        send_timestamp(MJD_1900_MAR01, 32'h0000_0001);
        send_timestamp(MJD_2100_FEB28, 32'hFFFF_FFFF);
        send_timestamp(MJD_2100_FEB28 + 18'd1, 32'h0000_0000);
        send_timestamp(18'd15020, 32'h4000_0000);                 // 1900-01-01
        // 2000 is a leap year; year end and a recent Feb 29
        send_timestamp(MJD_2000_JAN01, 32'h0000_0000);
        send_timestamp(MJD_2000_JAN01 + 18'd59, HOUR_FRAC);       // Feb 29
        send_timestamp(MJD_2000_JAN01 + 18'd60, HOUR_FRAC + 32'd1);
        send_timestamp(18'd60309, 32'hFFFF_FFFF);                 // 2023-12-31
        send_timestamp(18'd60369, 32'hC000_0000);                 // 2024-02-29
        // truncation on each side of a minute boundary
        send_timestamp(18'd60370, MINUTE_FRAC);
        send_timestamp(18'd60370, MINUTE_FRAC + 32'd1);

        // random: a long stretch in the middle runs with start held high
        for (int i = 0; i < NumRandom; i++) begin
            gaps_on = !(i >= 700 && i < 1100);
            send_timestamp(pick_days(), pick_fraction());
        end
        start <= 1'b0;

        // drain, then allow the full pipeline depth for any stray strobe
        while (n_pending != 0)
            @(posedge clk);
        repeat (PipeDepth + 4) @(posedge clk);

        $display("Converted %0d timestamps, %0d results compared field by field,",
                 n_accepted, n_checked);
        $display("across the full MJD range, century-rule edges and minute/hour edges.");
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
